@@ design/reuse_distance_histogram_assert.svh @@
// Assertion macros shared by the reuse-distance histogram modules.
`ifndef REUSE_DISTANCE_HISTOGRAM_ASSERT_SVH
`define REUSE_DISTANCE_HISTOGRAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RDH_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdh: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RDH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdh: next-cycle check failed");

`endif

@@ design/rdh_pkg.sv @@
// Shared constants, payload types and command codes of the reuse-distance histogram.
package rdh_pkg;

	localparam int NUM_SECTORS = 65536;
	localparam int NUM_BINS    = 2500;
	localparam int BIN_WIDTH   = 1;

	localparam int SECT_W     = $clog2(NUM_SECTORS);
	localparam int HIST_DEPTH = NUM_BINS + 1;
	localparam int HIST_W     = $clog2(HIST_DEPTH);

	// The clearing sweep covers the larger of the two memories.
	localparam int CLR_LEN = (NUM_SECTORS > HIST_DEPTH) ? NUM_SECTORS : HIST_DEPTH;
	localparam int CLR_W   = $clog2(CLR_LEN);

	// Distances at or above this limit land in the overflow bin, so the divider
	// only ever sees values below it.
	localparam longint DIST_LIMIT = longint'(NUM_BINS) * longint'(BIN_WIDTH);
	localparam int     DIST_W     = $clog2(DIST_LIMIT);

	// Exact division by BIN_WIDTH for all values below 2**DIST_W:
	// q = (d * RECIP) >> DIV_SH with RECIP = ceil(2**DIV_SH / BIN_WIDTH).
	localparam int     DIV_L   = $clog2(BIN_WIDTH);
	localparam int     DIV_SH  = DIST_W + DIV_L;
	localparam int     RECIP_W = DIST_W + 1;
	localparam longint RECIP   =
		((longint'(1) << DIV_SH) + longint'(BIN_WIDTH) - 1) / longint'(BIN_WIDTH);

	localparam logic [1:0] FN_WRITE  = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_WRITE,
		OP_DELETE,
		OP_READ
	} op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] sector;
		logic [11:0] bin_index;
	} rdh_in_t;

	typedef struct packed {
		logic        had_stamp;
		logic [11:0] bin_hit;
		logic [31:0] bin_count;
		logic [31:0] writes_so_far;
	} rdh_out_t;

	// Classified item as it waits in the queue between front and back.
	typedef struct packed {
		op_t               op;
		logic [SECT_W-1:0] sect;
		logic [HIST_W-1:0] bin;
	} rdh_cmd_t;

endpackage

@@ design/reuse_distance_histogram.sv @@
// Reuse-distance histogram top level: queue front end and memory back end.
// The result strobe is registered at the end of the idle state for an ignored item, of the
// read-out state for a bin read, of the stamp state for an event on a sector without a
// stamp, and of the histogram write state, after the stamp, divide and histogram read
// states, for an event that hits a stamped sector. The back-end sequencer takes one item
// at a time, and a two-entry queue takes items meanwhile. Results cannot be stalled.
// After reset busy stays high while both memories are swept clear.

module reuse_distance_histogram import rdh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rdh_in_t  cmd,
	output logic     busy,
	output logic     done,
	output rdh_out_t result
);

	rdh_cmd_t head;
	logic     avail;
	logic     pop;
	logic     clearing;

	rdh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.clearing (clearing),
		.pop      (pop),
		.head     (head),
		.avail    (avail)
	);

	rdh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.avail    (avail),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

@@ design/rdh_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
`include "reuse_distance_histogram_assert.svh"

module rdh_front import rdh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rdh_in_t  cmd,
	output logic     busy,
	input  logic     clearing,
	input  logic     pop,
	output rdh_cmd_t head,
	output logic     avail
);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	rdh_cmd_t          q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	rdh_cmd_t          cls;
	logic              sect_ok;
	logic              rd_ok;
	logic              push;

	assign sect_ok = 32'(cmd.sector) < 32'(NUM_SECTORS);
	assign rd_ok   = 32'(cmd.bin_index) <= 32'(NUM_BINS);

	// Out-of-range events and unused codes become plain no-ops here, so the
	// back end never has to look at them twice.
	always_comb begin
		cls.sect = SECT_W'(cmd.sector);
		cls.bin  = HIST_W'(cmd.bin_index);
		case (cmd.func)
			FN_WRITE:  cls.op = sect_ok ? OP_WRITE : OP_NOP;
			FN_DELETE: cls.op = sect_ok ? OP_DELETE : OP_NOP;
			FN_READ:   cls.op = rd_ok ? OP_READ : OP_NOP;
			default:   cls.op = OP_NOP;
		endcase
	end

	assign busy  = clearing || (count_q == CNT_W'(QDEPTH));
	assign push  = start && !busy;
	assign avail = count_q != CNT_W'(0);
	assign head  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`RDH_ASSERT_SAME(a_no_pop_empty, pop, count_q != CNT_W'(0))
	`RDH_ASSERT_NEXT(a_count_step, push && !pop, count_q == $past(count_q) + CNT_W'(1))
	`RDH_ASSERT_SAME(a_clear_empty, clearing, count_q == CNT_W'(0))

endmodule

@@ design/rdh_back.sv @@
// Back end: stamp and histogram memories, distance binning and result register.
`include "reuse_distance_histogram_assert.svh"

module rdh_back import rdh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rdh_cmd_t head,
	input  logic     avail,
	output logic     pop,
	output logic     clearing,
	output logic     done,
	output rdh_out_t result
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_STAMP,
		S_DIV,
		S_HREAD,
		S_HWRITE,
		S_RDOUT
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] stamp;
	} stamp_ent_t;

	localparam int PROD_W = DIST_W + RECIP_W;

	stamp_ent_t  stamp_mem [NUM_SECTORS];
	logic [31:0] hist_mem [HIST_DEPTH];

	state_t            state_q;
	logic [CLR_W-1:0]  clr_q;
	logic [31:0]       wc_q;
	logic              done_q;
	rdh_out_t          result_q;
	op_t               op_q;
	logic [SECT_W-1:0] sect_q;
	logic [DIST_W-1:0] dist_s1;
	logic              ovf_s1;
	logic [HIST_W-1:0] bin_s2;
	stamp_ent_t        stamp_rd_q;
	logic [31:0]       hist_rd_q;

	logic              stamp_we;
	logic [SECT_W-1:0] stamp_waddr;
	stamp_ent_t        stamp_wdata;
	logic              hist_we;
	logic [HIST_W-1:0] hist_waddr;
	logic [31:0]       hist_wdata;
	logic              hist_re;
	logic [HIST_W-1:0] hist_raddr;
	logic [31:0]       dist_now;
	logic [31:0]       wc_next;
	logic [PROD_W-1:0] prod;

	assign pop      = (state_q == S_IDLE) && avail;
	assign clearing = state_q == S_CLEAR;
	assign done     = done_q;
	assign result   = result_q;

	assign dist_now = wc_q - stamp_rd_q.stamp;
	assign wc_next  = (op_q == OP_WRITE) ? wc_q + 32'd1 : wc_q;
	assign prod     = PROD_W'(dist_s1) * PROD_W'(RECIP);

	always_comb begin
		stamp_we    = 1'b0;
		stamp_waddr = sect_q;
		stamp_wdata = '{valid: (op_q == OP_WRITE), stamp: wc_q};
		hist_we     = 1'b0;
		hist_waddr  = bin_s2;
		hist_wdata  = (hist_rd_q == 32'hFFFF_FFFF) ? hist_rd_q : hist_rd_q + 32'd1;
		case (state_q)
			S_CLEAR: begin
				stamp_we    = 32'(clr_q) < 32'(NUM_SECTORS);
				stamp_waddr = SECT_W'(clr_q);
				stamp_wdata = '{valid: 1'b0, stamp: 32'd0};
				hist_we     = 32'(clr_q) < 32'(HIST_DEPTH);
				hist_waddr  = HIST_W'(clr_q);
				hist_wdata  = 32'd0;
			end
			S_STAMP:  stamp_we = 1'b1;
			S_HWRITE: hist_we = 1'b1;
			default: begin
				stamp_we = 1'b0;
				hist_we  = 1'b0;
			end
		endcase
	end

	assign hist_re    = (pop && head.op == OP_READ) || (state_q == S_HREAD);
	assign hist_raddr = (state_q == S_IDLE) ? head.bin : bin_s2;

	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[stamp_waddr] <= stamp_wdata;
		end
		if (pop) begin
			stamp_rd_q <= stamp_mem[head.sect];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (hist_re) begin
			hist_rd_q <= hist_mem[hist_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= head.op;
			sect_q <= head.sect;
		end
		if (state_q == S_STAMP) begin
			dist_s1 <= DIST_W'(dist_now);
			ovf_s1  <= dist_now >= 32'(DIST_LIMIT);
		end
		if (state_q == S_DIV) begin
			bin_s2 <= ovf_s1 ? HIST_W'(NUM_BINS) : HIST_W'(prod >> DIV_SH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			wc_q     <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_LEN - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (avail) begin
						case (head.op)
							OP_WRITE, OP_DELETE: state_q <= S_STAMP;
							OP_READ:             state_q <= S_RDOUT;
							default: begin
								done_q   <= 1'b1;
								result_q <= '{had_stamp: 1'b0, bin_hit: 12'd0,
									bin_count: 32'd0, writes_so_far: wc_q};
							end
						endcase
					end
				end
				S_STAMP: begin
					wc_q <= wc_next;
					if (stamp_rd_q.valid) begin
						state_q <= S_DIV;
					end else begin
						done_q   <= 1'b1;
						result_q <= '{had_stamp: 1'b0, bin_hit: 12'd0,
							bin_count: 32'd0, writes_so_far: wc_next};
						state_q  <= S_IDLE;
					end
				end
				S_DIV:   state_q <= S_HREAD;
				S_HREAD: state_q <= S_HWRITE;
				S_HWRITE: begin
					done_q   <= 1'b1;
					result_q <= '{had_stamp: 1'b1, bin_hit: 12'(bin_s2),
						bin_count: 32'd0, writes_so_far: wc_q};
					state_q  <= S_IDLE;
				end
				S_RDOUT: begin
					done_q   <= 1'b1;
					result_q <= '{had_stamp: 1'b0, bin_hit: 12'd0,
						bin_count: hist_rd_q, writes_so_far: wc_q};
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RDH_ASSERT_NEXT(a_wc_step, state_q == S_STAMP && op_q == OP_WRITE,
		wc_q == $past(wc_q) + 32'd1)
	`RDH_ASSERT_SAME(a_bin_range, state_q == S_HREAD, bin_s2 <= HIST_W'(NUM_BINS))
	`RDH_ASSERT_SAME(a_clear_quiet, state_q == S_CLEAR, !avail && !done_q)

endmodule
